// ===== rtl/pva_pkg.sv =====
package pva_pkg;

    // Configuration register
    localparam int         ACTIVE_W     = 6;
    localparam logic [5:0] ACTIVE_RESET = 6'd32;

    // Request codes
    localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [1:0] REQ_WRITE    = 2'd2;
    localparam logic [1:0] REQ_CLEANUP  = 2'd3;

    // Envelope phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    // Note-on pick rules
    localparam logic [1:0] RULE_IDLE    = 2'd0;
    localparam logic [1:0] RULE_RELEASE = 2'd1;
    localparam logic [1:0] RULE_OLDEST  = 2'd2;

    // Held note value meaning "none"
    localparam logic [7:0] NO_NOTE = 8'hFF;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [6:0]        note;
        logic [4:0]        target_voice;
        logic [1:0]        phase;
        logic [15:0]       level;
        logic [31:0]       order;
        logic signed [7:0] held_note;
    } pva_in_t;

    typedef struct packed {
        logic [4:0] chosen_voice;
        logic       found;
        logic [1:0] pick_rule;
    } pva_out_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
        logic out_load;
    } pva_cmd_t;

    typedef struct packed {
        logic write_req;
        logic n_zero;
        logic last_rd;
    } pva_status_t;

endpackage

// ===== rtl/pva_ram.sv =====
module pva_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pva_ctrl.sv =====
module pva_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pva_pkg::pva_status_t status,
    output pva_pkg::pva_cmd_t    cmd
);
    import pva_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Scan table and commit (not for writes or n = 0), then hand over result
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.write_req || status.n_zero)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (status.last_rd)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && status.last_rd |=> state_reg == S_DRAIN)
        else $error("scan did not end after the last voice");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result load did not raise out_valid");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && !status.write_req && !status.n_zero |=> state_reg == S_SCAN)
        else $error("scan request did not start a scan");

endmodule

// ===== rtl/pva_dp.sv =====
module pva_dp #(
    parameter int MAX_VOICES = 32,
    parameter int ORDER_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [5:0]           cfg_data,
    input  pva_pkg::pva_in_t     in_data,
    output pva_pkg::pva_out_t    out_data,
    input  pva_pkg::pva_cmd_t    cmd,
    output pva_pkg::pva_status_t status
);
    import pva_pkg::*;

    localparam int AW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CW    = $clog2(MAX_VOICES + 1);
    localparam int LW    = CW + 1;
    localparam int REC_W = 26 + ORDER_BITS;
    localparam logic [REC_W-1:0] RESET_REC = {PH_IDLE, 16'h0000, {ORDER_BITS{1'b0}}, NO_NOTE};

    // Voice index to the 5-bit result field
    function automatic logic [4:0] to_voice(input logic [AW-1:0] idx);
        logic [8:0] ext;
        ext = 9'(idx);
        return ext[4:0];
    endfunction

    logic [5:0]            active_reg;
    logic [CW-1:0]         n_now;
    logic [CW-1:0]         n_reg;
    logic [1:0]            req_reg;
    logic [6:0]            note_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic [LW-1:0]         rd_cnt_next;
    logic                  exam_vld_reg;
    logic [AW-1:0]         exam_idx_reg;
    logic [MAX_VOICES-1:0] valid_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [REC_W-1:0]      ram_wdata;
    logic [REC_W-1:0]      ram_rdata;

    logic [REC_W-1:0]      e_rec;
    logic [1:0]            e_phase;
    logic [15:0]           e_level;
    logic [ORDER_BITS-1:0] e_order;
    logic [7:0]            e_note;
    logic                  e_idle;
    logic                  e_rel;
    logic                  e_match;
    logic                  ord_cand;
    logic                  clean_hit;

    logic                  have_idle_reg;
    logic [AW-1:0]         idle_idx_reg;
    logic                  have_rel_reg;
    logic [AW-1:0]         rel_idx_reg;
    logic [15:0]           rel_level_reg;
    logic                  have_ord_reg;
    logic [AW-1:0]         ord_idx_reg;
    logic [ORDER_BITS-1:0] ord_val_reg;
    logic                  have_clr_reg;
    logic                  have_clr_rel_reg;
    logic [AW-1:0]         clr_idx_reg;
    logic [REC_W-1:0]      clr_rec_reg;

    logic [8:0]            tgt_ext;
    logic                  tgt_ok;
    logic [63:0]           ord_in_ext;
    pva_out_t              res;
    pva_out_t              out_data_reg;

    // Clamp the voice count to the table size
    assign n_now = (32'(active_reg) > MAX_VOICES) ? CW'(MAX_VOICES) : CW'(active_reg);

    assign rd_cnt_next      = LW'(rd_idx_reg) + LW'(1);
    assign status.write_req = (in_data.req_type == REQ_WRITE);
    assign status.n_zero    = (n_now == '0);
    assign status.last_rd   = (rd_cnt_next == LW'(n_reg));

    assign tgt_ext    = 9'(in_data.target_voice);
    assign tgt_ok     = (tgt_ext < 9'(MAX_VOICES));
    assign ord_in_ext = 64'(in_data.order);

    // Unwritten entries read as the reset record
    assign e_rec     = valid_reg[exam_idx_reg] ? ram_rdata : RESET_REC;
    assign e_phase   = e_rec[REC_W-1 -: 2];
    assign e_level   = e_rec[REC_W-3 -: 16];
    assign e_order   = e_rec[8 +: ORDER_BITS];
    assign e_note    = e_rec[7:0];
    assign e_idle    = (e_phase == PH_IDLE);
    assign e_rel     = (e_phase == PH_RELEASE);
    assign e_match   = (e_note == {1'b0, note_reg});
    assign ord_cand  = (req_reg == REQ_NOTE_ON) ||
                       ((req_reg == REQ_NOTE_OFF) && e_match && !e_idle && !e_rel);
    assign clean_hit = exam_vld_reg && (req_reg == REQ_CLEANUP) && e_idle && !e_note[7];

    // Select the one table write of this cycle
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = tgt_ext[AW-1:0];
        ram_wdata = {in_data.phase, in_data.level, ord_in_ext[ORDER_BITS-1:0],
                     in_data.held_note};
        priority if (cmd.load && status.write_req && tgt_ok)
        begin
            ram_we = 1'b1;
        end
        else if (clean_hit)
        begin
            ram_we    = 1'b1;
            ram_waddr = exam_idx_reg;
            ram_wdata = {e_rec[REC_W-1:8], NO_NOTE};
        end
        else if (cmd.commit && (req_reg == REQ_NOTE_OFF) && !have_ord_reg && have_clr_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = {clr_rec_reg[REC_W-1:8], NO_NOTE};
        end
        else
        begin
            ram_we = 1'b0;
        end
    end

    pva_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_VOICES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Hold the register, flags and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= ACTIVE_RESET;
            exam_vld_reg     <= 1'b0;
            valid_reg        <= '0;
            have_idle_reg    <= 1'b0;
            have_rel_reg     <= 1'b0;
            have_ord_reg     <= 1'b0;
            have_clr_reg     <= 1'b0;
            have_clr_rel_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end
            exam_vld_reg <= cmd.rd_en;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.load)
            begin
                have_idle_reg    <= 1'b0;
                have_rel_reg     <= 1'b0;
                have_ord_reg     <= 1'b0;
                have_clr_reg     <= 1'b0;
                have_clr_rel_reg <= 1'b0;
            end
            else if (exam_vld_reg)
            begin
                if ((req_reg == REQ_NOTE_ON) && e_idle)
                begin
                    have_idle_reg <= 1'b1;
                end
                if ((req_reg == REQ_NOTE_ON) && e_rel)
                begin
                    have_rel_reg <= 1'b1;
                end
                if (ord_cand)
                begin
                    have_ord_reg <= 1'b1;
                end
                if ((req_reg == REQ_NOTE_OFF) && e_match && (e_rel || e_idle))
                begin
                    have_clr_reg <= 1'b1;
                end
                if ((req_reg == REQ_NOTE_OFF) && e_match && e_rel)
                begin
                    have_clr_rel_reg <= 1'b1;
                end
            end
        end
    end

    // Load the request, step the scan pointer, track the best candidates and hold the result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= in_data.req_type;
            note_reg   <= in_data.note;
            n_reg      <= n_now;
            rd_idx_reg <= '0;
        end
        else if (cmd.rd_en)
        begin
            rd_idx_reg <= rd_cnt_next[AW-1:0];
        end
        if (cmd.rd_en)
        begin
            exam_idx_reg <= rd_idx_reg;
        end
        if (exam_vld_reg && !cmd.load)
        begin
            if ((req_reg == REQ_NOTE_ON) && e_idle && !have_idle_reg)
            begin
                idle_idx_reg <= exam_idx_reg;
            end
            if ((req_reg == REQ_NOTE_ON) && e_rel && (!have_rel_reg || e_level < rel_level_reg))
            begin
                rel_idx_reg   <= exam_idx_reg;
                rel_level_reg <= e_level;
            end
            if (ord_cand && (!have_ord_reg || e_order < ord_val_reg))
            begin
                ord_idx_reg <= exam_idx_reg;
                ord_val_reg <= e_order;
            end
            // First releasing match wins, else first idle match
            if ((req_reg == REQ_NOTE_OFF) && e_match &&
                ((e_rel && !have_clr_rel_reg) || (e_idle && !have_clr_reg)))
            begin
                clr_idx_reg <= exam_idx_reg;
                clr_rec_reg <= e_rec;
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res;
        end
    end

    // Form the result from the trackers
    always_comb
    begin
        res = '0;
        unique case (req_reg)
            REQ_NOTE_ON:
            begin
                priority if (have_idle_reg)
                begin
                    res = '{chosen_voice: to_voice(idle_idx_reg), found: 1'b1,
                            pick_rule: RULE_IDLE};
                end
                else if (have_rel_reg)
                begin
                    res = '{chosen_voice: to_voice(rel_idx_reg), found: 1'b1,
                            pick_rule: RULE_RELEASE};
                end
                else if (have_ord_reg)
                begin
                    res = '{chosen_voice: to_voice(ord_idx_reg), found: 1'b1,
                            pick_rule: RULE_OLDEST};
                end
                else
                begin
                    res = '0;
                end
            end
            REQ_NOTE_OFF:
            begin
                if (have_ord_reg)
                begin
                    res = '{chosen_voice: to_voice(ord_idx_reg), found: 1'b1,
                            pick_rule: RULE_IDLE};
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    assign out_data = out_data_reg;

    a_exam_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        exam_vld_reg |-> LW'(exam_idx_reg) < LW'(n_reg))
        else $error("examined voice beyond the voices in use");

    a_commit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !exam_vld_reg)
        else $error("commit while the scan is still in flight");

    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(ram_waddr)])
        else $error("written voice not marked valid");

endmodule

// ===== rtl/polyphonic_voice_allocator_unit.sv =====
// Record write: accepted in idle, then the done state loads the result; the next item is accepted
// back in idle. Note on, note off, cleanup: scan, drain, commit and done states, the scan being one
// pass over the voice RAM read port, one voice per cycle, for n = min(active_voices, MAX_VOICES)
// voices. With n = 0 these behave like a record write. The done state waits for a free output.
// Reset: all voices idle, level and order 0, no held note (per-voice valid bits, no clear
// pass), active_voices = 32; the block is ready straight out of reset.
module polyphonic_voice_allocator_unit #(
    parameter int MAX_VOICES = 32,
    parameter int ORDER_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [5:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  pva_pkg::pva_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pva_pkg::pva_out_t out_data
);
    import pva_pkg::*;

    pva_cmd_t    cmd;
    pva_status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    pva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pva_dp #(
        .MAX_VOICES (MAX_VOICES),
        .ORDER_BITS (ORDER_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .out_data (out_data),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
